// File: design/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Types and codes shared by the double-ended queue controller and datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_BACK   = 2'd2,
    ACT_POP_FRONT  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    action_e                    action;
    logic signed [WORD_W-1:0]   value;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]   popped_word;
    status_e                    status;
    logic signed [WORD_W-1:0]   front_word;
    logic signed [WORD_W-1:0]   back_word;
    logic        [OCC_W-1:0]    occupancy;
    logic                       is_empty;
  } out_word_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic read_ends;
    logic load_out;
  } dq_cmd_t;

endpackage
`default_nettype wire

// File: design/dq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: accepts a word, steps the datapath through update, end reads
// and result load, and owns the output valid flag.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output dq_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ENDS,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_item = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec      = (state_q == S_EXEC);
    cmd_o.read_ends = (state_q == S_ENDS);
    cmd_o.load_out  = (state_q == S_DONE) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_ENDS;
        end
        S_ENDS: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/dq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_datapath
// Ring store with head, tail and count registers, end word reads and the
// result register.
// ----------------------------------------------------------------------------
module dq_datapath
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire dq_cmd_t  cmd_i,
  input  wire in_word_t in_word_i,
  output out_word_t     out_word_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic [WORD_W-1:0] mem [CAPACITY];

  action_e           act_q;
  logic [WORD_W-1:0] val_q;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  status_e           status_q, status_d;
  logic              pop_ok_q, pop_ok_d;
  logic [WORD_W-1:0] popped_q;
  logic [WORD_W-1:0] rd_a_q, rd_b_q;
  out_word_t         out_q, out_d;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr, rd_a_addr, rd_b_addr;
  logic [IDX_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;
  logic              full, empty;

  assign head_inc = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? IDX_LAST : head_q - 1'b1;
  assign tail_inc = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? IDX_LAST : tail_q - 1'b1;
  assign full     = (cnt_q == CNT_FULL);
  assign empty    = (cnt_q == '0);

  // action decode
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    status_d  = ST_DONE;
    pop_ok_d  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = tail_q;
    rd_a_addr = head_q;
    rd_b_addr = tail_dec;
    case (act_q)
      ACT_PUSH_BACK: begin
        if (full) begin
          status_d = ST_PUSH_FULL;
        end else begin
          wr_en   = cmd_i.exec;
          wr_addr = tail_q;
          tail_d  = tail_inc;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_PUSH_FULL;
        end else begin
          wr_en   = cmd_i.exec;
          wr_addr = head_dec;
          head_d  = head_dec;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          pop_ok_d  = 1'b1;
          rd_a_addr = tail_dec;
          tail_d    = tail_dec;
          cnt_d     = cnt_q - 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          pop_ok_d  = 1'b1;
          rd_a_addr = head_q;
          head_d    = head_inc;
          cnt_d     = cnt_q - 1'b1;
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
    if (!cmd_i.exec) begin
      rd_a_addr = head_q;
    end
  end

  always_comb begin
    out_d             = out_q;
    out_d.popped_word = popped_q;
    out_d.status      = status_q;
    out_d.front_word  = empty ? '0 : rd_a_q;
    out_d.back_word   = empty ? '0 : rd_b_q;
    out_d.occupancy   = OCC_W'(cnt_q);
    out_d.is_empty    = empty;
  end

  // ring store, registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= val_q;
    end
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q <= in_word_i.action;
      val_q <= in_word_i.value;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
    if (cmd_i.read_ends) begin
      popped_q <= pop_ok_q ? rd_a_q : '0;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_word_o = out_q;

endmodule
`default_nettype wire

// File: design/double_ended_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of 32-bit words in a ring store.
// Result path: update, end read and result load through the registered store
// read ports, then result valid; the load waits for a free output register.
// A new word is taken only once the last result is loaded; a result may wait
// in the output register while the next word is taken.
// Reset: async active low; deque empty, indices zero, store contents left
// unwritten.
// ----------------------------------------------------------------------------
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_word_t in_word_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_word_t     out_word_o
);

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule
`default_nettype wire
